### rtl/core/sip_non_invite_client_transaction_macros.svh
// Assertion helpers used by the transaction FSM.
`ifndef SIP_NON_INVITE_CLIENT_TRANSACTION_MACROS_SVH
`define SIP_NON_INVITE_CLIENT_TRANSACTION_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SIPNICT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SIPNICT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sipnict_pkg.sv
package sipnict_pkg;

	localparam int FUNC_W     = 3;
	localparam int CODE_W     = 10;
	localparam int STATUS_W   = 2;
	localparam int NOTIFY_W   = 2;
	localparam int PHASE_W    = 2;
	localparam int IVL_W      = 16;
	localparam int F_SHIFT    = 6;
	localparam int F_IVL_W    = IVL_W + F_SHIFT;
	localparam int CFG_IDX_W  = 2;

	// Event codes.
	localparam logic [FUNC_W-1:0] FN_REQUEST   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_RESPONSE  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_TIMER_E   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_TIMER_F   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_TIMER_K   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_XPORT_ERR = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MSG_ERR     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_XPORT_ERR   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_WRONG_PHASE = 2'd3;

	// Error notices.
	localparam logic [NOTIFY_W-1:0] NT_NONE    = 2'd0;
	localparam logic [NOTIFY_W-1:0] NT_TIMEOUT = 2'd1;
	localparam logic [NOTIFY_W-1:0] NT_XPORT   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINGER = 2'd2;

	localparam logic [IVL_W-1:0] BASE_RST   = 16'd500;
	localparam logic [IVL_W-1:0] MAX_RST    = 16'd4000;
	localparam logic [IVL_W-1:0] LINGER_RST = 16'd5000;

	// Status code classes.
	localparam logic [CODE_W-1:0] CODE_PROV_LO  = 10'd100;
	localparam logic [CODE_W-1:0] CODE_PROV_HI  = 10'd199;
	localparam logic [CODE_W-1:0] CODE_FINAL_LO = 10'd200;
	localparam logic [CODE_W-1:0] CODE_FINAL_HI = 10'd799;

	typedef struct packed {
		logic [IVL_W-1:0] base_interval;
		logic [IVL_W-1:0] max_interval;
		logic [IVL_W-1:0] linger_interval;
	} cfg_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CODE_W-1:0] status_code;
		logic              parse_ok;
		logic              send_ok;
	} ev_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                send_request;
		logic                deliver_response;
		logic [NOTIFY_W-1:0] notify_error;
		logic                end_transaction;
		logic                arm_e;
		logic [IVL_W-1:0]    e_interval;
		logic                arm_f;
		logic [F_IVL_W-1:0]  f_interval;
		logic                arm_k;
		logic [IVL_W-1:0]    k_interval;
		logic [PHASE_W-1:0]  phase_out;
	} res_t;

endpackage

### rtl/core/sipnict_ev_if.sv
interface sipnict_ev_if import sipnict_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CODE_W-1:0] status_code;
	logic              parse_ok;
	logic              send_ok;

	modport source (output valid, func, status_code, parse_ok, send_ok, input ready);
	modport sink (input valid, func, status_code, parse_ok, send_ok, output ready);
endinterface

### rtl/core/sipnict_res_if.sv
interface sipnict_res_if import sipnict_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                send_request;
	logic                deliver_response;
	logic [NOTIFY_W-1:0] notify_error;
	logic                end_transaction;
	logic                arm_e;
	logic [IVL_W-1:0]    e_interval;
	logic                arm_f;
	logic [F_IVL_W-1:0]  f_interval;
	logic                arm_k;
	logic [IVL_W-1:0]    k_interval;
	logic [PHASE_W-1:0]  phase_out;

	modport source (output valid, status, send_request, deliver_response, notify_error,
		end_transaction, arm_e, e_interval, arm_f, f_interval, arm_k, k_interval,
		phase_out, input ready);
	modport sink (input valid, status, send_request, deliver_response, notify_error,
		end_transaction, arm_e, e_interval, arm_f, f_interval, arm_k, k_interval,
		phase_out, output ready);
endinterface

### rtl/core/sipnict_cfg.sv
module sipnict_cfg import sipnict_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [CFG_IDX_W-1:0] index,
	input  logic [IVL_W-1:0]     wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_interval   <= BASE_RST;
			cfg_q.max_interval    <= MAX_RST;
			cfg_q.linger_interval <= LINGER_RST;
		end else if (we) begin
			unique case (index)
				REG_BASE:   cfg_q.base_interval   <= wdata;
				REG_MAX:    cfg_q.max_interval    <= wdata;
				REG_LINGER: cfg_q.linger_interval <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/sipnict_fsm.sv
`include "sip_non_invite_client_transaction_macros.svh"

module sipnict_fsm import sipnict_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic ev_valid,
	output logic ev_ready,
	input  ev_t  ev,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	typedef enum logic [PHASE_W-1:0] {
		TRYING     = 2'd0,
		PROCEEDING = 2'd1,
		COMPLETED  = 2'd2,
		TERMINATED = 2'd3
	} phase_t;

	phase_t           phase_q, nxt_phase;
	logic [IVL_W-1:0] retx_q, nxt_retx;
	logic             stored_q, nxt_stored;
	logic             res_valid_q;
	res_t             res_q, r;
	logic [IVL_W:0]   dbl;
	logic [IVL_W-1:0] capped;
	logic             live;
	logic             accept;

	// The result register frees up in the same cycle it is drained.
	assign ev_ready = !res_valid_q || res_ready;
	assign accept   = ev_valid && ev_ready;

	assign live   = (phase_q == TRYING) || (phase_q == PROCEEDING);
	assign dbl    = {retx_q, 1'b0};
	assign capped = ({1'b0, cfg.max_interval} > dbl) ? dbl[IVL_W-1:0] : cfg.max_interval;

	always_comb begin
		nxt_phase  = phase_q;
		nxt_retx   = retx_q;
		nxt_stored = stored_q;
		r          = '0;
		unique case (ev.func)
			FN_REQUEST: begin
				if (phase_q != TRYING) begin
					r.status = ST_WRONG_PHASE;
				end else begin
					// A request is held even when it fails to parse.
					nxt_stored = 1'b1;
					if (!ev.parse_ok) begin
						r.status = ST_MSG_ERR;
					end else if (!ev.send_ok) begin
						nxt_phase = TERMINATED;
						r.status  = ST_XPORT_ERR;
					end else begin
						r.send_request = 1'b1;
						nxt_retx       = cfg.base_interval;
						r.arm_e        = 1'b1;
						r.e_interval   = cfg.base_interval;
						r.arm_f        = 1'b1;
						r.f_interval   = {cfg.base_interval, {F_SHIFT{1'b0}}};
					end
				end
			end
			FN_RESPONSE: begin
				if (live) begin
					if (ev.status_code >= CODE_PROV_LO && ev.status_code <= CODE_PROV_HI) begin
						nxt_phase          = PROCEEDING;
						r.deliver_response = 1'b1;
					end else if (ev.status_code >= CODE_FINAL_LO &&
							ev.status_code <= CODE_FINAL_HI) begin
						nxt_phase          = COMPLETED;
						r.deliver_response = 1'b1;
						r.arm_k            = 1'b1;
						r.k_interval       = cfg.linger_interval;
					end
				end
			end
			FN_TIMER_E: begin
				if (live && stored_q) begin
					r.send_request = 1'b1;
					r.arm_e        = 1'b1;
					if (phase_q == TRYING) begin
						nxt_retx     = capped;
						r.e_interval = capped;
					end else begin
						r.e_interval = cfg.max_interval;
					end
				end
			end
			FN_TIMER_F: begin
				if (live) begin
					r.notify_error    = NT_TIMEOUT;
					nxt_phase         = TERMINATED;
					r.end_transaction = stored_q;
				end
			end
			FN_TIMER_K: begin
				nxt_phase         = TERMINATED;
				r.end_transaction = stored_q;
			end
			FN_XPORT_ERR: begin
				r.notify_error    = NT_XPORT;
				nxt_phase         = TERMINATED;
				r.end_transaction = stored_q;
			end
			default: ;
		endcase
		r.phase_out = nxt_phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= TRYING;
			retx_q      <= BASE_RST;
			stored_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (accept) begin
			phase_q     <= nxt_phase;
			retx_q      <= nxt_retx;
			stored_q    <= nxt_stored;
			res_valid_q <= 1'b1;
			res_q       <= r;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SIPNICT_ASSERT_NEXT(a_term_sticky, clk, arst_n, phase_q == TERMINATED, phase_q == TERMINATED, "terminated phase was left")
	`SIPNICT_ASSERT_NEXT(a_stored_sticky, clk, arst_n, stored_q, stored_q, "stored request was dropped")
	`SIPNICT_ASSERT_NEXT(a_accept_result, clk, arst_n, accept, res_valid_q, "accepted item produced no result")
	`SIPNICT_ASSERT_IMPL(a_end_is_term, clk, arst_n, res_valid_q && res_q.end_transaction, res_q.phase_out == TERMINATED, "end announced outside terminated")

endmodule

### rtl/core/sip_non_invite_client_transaction.sv
// Channel   Dir  Contents
// evt       in   func, status_code, parse_ok, send_ok
// res       out  status, send/deliver/notify/end flags, timer arms and intervals, phase_out
// cfg_*     in   write of base, max and linger intervals, indexes 0 to 2
//
// Each event is decoded combinationally against the phase registers and its result
// appears in the result register on the next cycle; one event per cycle is sustained
// while res.ready is high, and events are taken while the result register is empty
// or is being drained. Reset returns the phase to trying, loads the retransmit interval
// with 500 ticks and loads the interval registers with 500, 4000 and 5000 ticks.
module sip_non_invite_client_transaction import sipnict_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IVL_W-1:0]     cfg_wdata,
	sipnict_ev_if.sink           evt,
	sipnict_res_if.source        res
);

	cfg_t cfg;
	ev_t  ev;
	res_t r;

	sipnict_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	assign ev.func        = evt.func;
	assign ev.status_code = evt.status_code;
	assign ev.parse_ok    = evt.parse_ok;
	assign ev.send_ok     = evt.send_ok;

	sipnict_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ev_valid  (evt.valid),
		.ev_ready  (evt.ready),
		.ev        (ev),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res       (r)
	);

	assign res.status           = r.status;
	assign res.send_request     = r.send_request;
	assign res.deliver_response = r.deliver_response;
	assign res.notify_error     = r.notify_error;
	assign res.end_transaction  = r.end_transaction;
	assign res.arm_e            = r.arm_e;
	assign res.e_interval       = r.e_interval;
	assign res.arm_f            = r.arm_f;
	assign res.f_interval       = r.f_interval;
	assign res.arm_k            = r.arm_k;
	assign res.k_interval       = r.k_interval;
	assign res.phase_out        = r.phase_out;

endmodule
